@@ sv/scml_pkg.sv @@
package scml_pkg;

  localparam int LINE_BYTES_DEF = 32;
  localparam int KEY_COUNT      = 4;
  localparam int KEY_MAX        = 14;
  localparam int LEN_W          = 6;

  localparam logic [7:0] CODE_END  = 8'd13;
  localparam logic [7:0] CODE_BACK = 8'd8;

  // Every keyword starts with the same pin prefix.
  localparam logic [39:0] KEY_HEAD = "PA15_";

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_OK    = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KEY_ON        = 2'd0,
    KEY_OFF       = 2'd1,
    KEY_BLINK_ON  = 2'd2,
    KEY_BLINK_OFF = 2'd3
  } key_t;

  typedef logic [KEY_MAX-1:0][7:0] line_t;

  typedef struct packed {
    logic hit;
    key_t index;
  } match_t;

  typedef struct packed {
    status_t          status;
    key_t             index;
    logic             level;
    logic             blink;
    logic [LEN_W-1:0] length;
  } result_t;

  function automatic int key_len(input key_t k);
    int n;
    n = 0;
    unique case (k)
      KEY_ON:        n = 7;
      KEY_OFF:       n = 8;
      KEY_BLINK_ON:  n = 13;
      KEY_BLINK_OFF: n = 14;
      default:       n = 0;
    endcase
    return n;
  endfunction

  // Characters are numbered from the start of the keyword.
  function automatic logic [7:0] key_byte(input key_t k, input int i);
    logic [8*KEY_MAX-1:0] s;
    int                   pos;
    s = '0;
    unique case (k)
      KEY_ON:        s = {KEY_HEAD, "on"};
      KEY_OFF:       s = {KEY_HEAD, "off"};
      KEY_BLINK_ON:  s = {KEY_HEAD, "blink_on"};
      KEY_BLINK_OFF: s = {KEY_HEAD, "blink_off"};
      default:       s = '0;
    endcase
    pos = key_len(k) - 1 - i;
    return s[8*pos +: 8];
  endfunction

endpackage

@@ sv/serial_command_line_matcher.sv @@
// Serial command line matcher.
// The input channel takes one received byte per request on in_rx_byte. Bytes
// are collected into a line; backspace removes the last stored byte and
// carriage return ends the line. Only the end of a line yields a request on
// the result channel, carrying the status, the matched keyword, the pin level
// and blink enable after the line, and the stored line length.
// A new byte can be accepted in every cycle while in_ready is high.
// The result of a carriage return goes to the result register, or to the skid
// stage while that one is held; the keyword compare over the stored line and
// the flag update sit between the line registers and the result register.
// A result register and a one-entry skid stage follow the compare, so bytes
// keep being accepted while one result waits; in_ready falls only when both
// hold a result that the receiver has not taken.
// Reset empties the line, clears the overflow mark, the pin level and the
// blink enable, and drops any result not yet taken.
module serial_command_line_matcher
  import scml_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_line_status,
  output logic [1:0]       out_matched_index,
  output logic             out_output_level,
  output logic             out_blink_enable,
  output logic [LEN_W-1:0] out_line_length
);

  localparam int CNT_W = $clog2(LINE_BYTES + 1);

  line_t            line_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             ovf_r, ovf_nxt;
  logic             level_r, level_nxt;
  logic             blink_r, blink_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  result_t          out_r, out_nxt;
  result_t          skid_r, skid_nxt;

  logic    in_fire;
  logic    is_end;
  logic    store_wr;
  match_t  match;
  result_t res;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign is_end   = (in_rx_byte == CODE_END);
  assign store_wr = in_fire && !is_end && (in_rx_byte != CODE_BACK)
                    && (fill_r != CNT_W'(LINE_BYTES));

  scml_keyword_match #(
    .LINE_BYTES(LINE_BYTES)
  ) u_match (
    .line_bytes(line_r),
    .fill_count(fill_r),
    .match     (match)
  );

  always_comb begin
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    level_nxt = level_r;
    blink_nxt = blink_r;
    res.status = ST_EMPTY;
    res.index  = KEY_ON;
    if (ovf_r) begin
      res.status = ST_ERROR;
    end else if (fill_r != '0) begin
      if (match.hit) begin
        res.status = ST_OK;
        res.index  = match.index;
      end else begin
        res.status = ST_ERROR;
      end
    end
    if (in_fire) begin
      if (is_end) begin
        if (res.status == ST_OK) begin
          unique case (res.index)
            KEY_ON:        level_nxt = 1'b1;
            KEY_OFF:       level_nxt = 1'b0;
            KEY_BLINK_ON:  blink_nxt = 1'b1;
            KEY_BLINK_OFF: blink_nxt = 1'b0;
            default:       level_nxt = level_r;
          endcase
        end
        fill_nxt = '0;
        ovf_nxt  = 1'b0;
      end else if (in_rx_byte == CODE_BACK) begin
        if (fill_r != '0) begin
          fill_nxt = fill_r - CNT_W'(1);
        end
      end else if (fill_r == CNT_W'(LINE_BYTES)) begin
        ovf_nxt = 1'b1;
      end else begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
    res.level  = level_nxt;
    res.blink  = blink_nxt;
    res.length = ({{(32 - CNT_W){1'b0}}, fill_r} > 32'd63) ? LEN_W'(63)
                                                           : LEN_W'(fill_r);
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (in_fire && is_end) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_fire && is_end) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      ovf_r        <= 1'b0;
      level_r      <= 1'b0;
      blink_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      ovf_r        <= ovf_nxt;
      level_r      <= level_nxt;
      blink_r      <= blink_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // Only the leading bytes that a keyword can cover are kept.
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEY_MAX; i++) begin
      if (store_wr && (fill_r == CNT_W'(i))) begin
        line_r[i] <= in_rx_byte;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_status   = out_r.status;
  assign out_matched_index = out_r.index;
  assign out_output_level  = out_r.level;
  assign out_blink_enable  = out_r.blink;
  assign out_line_length   = out_r.length;

endmodule

@@ sv/scml_keyword_match.sv @@
module scml_keyword_match
  import scml_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  localparam int CNT_W = $clog2(LINE_BYTES + 1)
) (
  input  line_t            line_bytes,
  input  logic [CNT_W-1:0] fill_count,
  output match_t           match
);

  logic [KEY_COUNT-1:0] eq;

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    localparam key_t KEY = key_t'(k);
    localparam int   LEN = key_len(KEY);
    logic [LEN-1:0]  ch_eq;
    for (genvar i = 0; i < LEN; i++) begin : g_ch
      assign ch_eq[i] = (line_bytes[i] == key_byte(KEY, i));
    end
    assign eq[k] = (fill_count == CNT_W'(LEN)) && (&ch_eq);
  end

  always_comb begin
    match = '{hit: 1'b0, index: KEY_ON};
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (eq[k]) begin
        match.hit   = 1'b1;
        match.index = key_t'(k);
      end
    end
  end

endmodule
